[sv/sba_pkg.sv]
// shared types, constants and the binary to bcd conversion for the bcd score accumulator
package sba_pkg;

    localparam int DIGIT_COUNT = 6;
    localparam int DIGIT_W     = 4;
    localparam int OUT_DIGITS  = 6;
    localparam int AMOUNT_W    = 16;
    localparam int MARK_W      = 7;

    // low and high digit of the ten-thousands count
    localparam int TEN_K_LO = 4;
    localparam int TEN_K_HI = 5;

    localparam logic [MARK_W-1:0] MARK_MAX = 7'd99;

    // command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_SUB   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // reciprocal constants for exact division of a 16-bit value
    localparam logic [32:0] RECIP_10    = 33'd52429;
    localparam logic [32:0] RECIP_100   = 33'd83887;
    localparam logic [32:0] RECIP_1000  = 33'd67109;
    localparam logic [32:0] RECIP_10000 = 33'd107375;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef digit_t [DIGIT_COUNT-1:0] digits_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [AMOUNT_W-1:0] amount;
    } cmd_word_t;

    typedef struct packed {
        logic [OUT_DIGITS*DIGIT_W-1:0] total_bcd;
        logic [MARK_W-1:0]             milestones_gained;
        logic                          clamped;
        logic                          wrapped;
    } res_word_t;

    // command held in the input register, amount already in bcd
    typedef struct packed {
        logic [1:0] command;
        digits_t    operand;
    } op_item_t;

    // state update and result from the digit alu
    typedef struct packed {
        digits_t           total;
        logic [MARK_W-1:0] mark;
        res_word_t         res;
    } alu_out_t;

    // five decimal digits of a 16-bit value, each quotient taken by its own reciprocal
    function automatic digits_t to_bcd(input logic [AMOUNT_W-1:0] value);
        logic [32:0] p1;
        logic [32:0] p2;
        logic [32:0] p3;
        logic [32:0] p4;
        logic [12:0] q1;
        logic [9:0]  q2;
        logic [6:0]  q3;
        logic [2:0]  q4;
        logic [15:0] r0;
        logic [15:0] r1;
        logic [15:0] r2;
        logic [15:0] r3;
        digits_t     d;
        p1 = 33'(value) * RECIP_10;
        p2 = 33'(value) * RECIP_100;
        p3 = 33'(value) * RECIP_1000;
        p4 = 33'(value) * RECIP_10000;
        q1 = p1[31:19];
        q2 = p2[32:23];
        q3 = p3[32:26];
        q4 = p4[32:30];
        r0 = value - 16'(16'(q1) * 16'd10);
        r1 = 16'(q1) - 16'(16'(q2) * 16'd10);
        r2 = 16'(q2) - 16'(16'(q3) * 16'd10);
        r3 = 16'(q3) - 16'(16'(q4) * 16'd10);
        d = '0;
        d[0] = r0[DIGIT_W-1:0];
        d[1] = r1[DIGIT_W-1:0];
        d[2] = r2[DIGIT_W-1:0];
        d[3] = r3[DIGIT_W-1:0];
        d[4] = {1'b0, q4};
        return d;
    endfunction

endpackage

[sv/sba_in_stage.sv]
// input register: converts the amount to bcd and holds one command word
module sba_in_stage
    import sba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_word_t cmd_word,
    input  logic      take,
    output logic      held_valid,
    output op_item_t  held_item
);

    logic     held_valid_reg;
    logic     held_valid_next;
    op_item_t held_item_reg;

    assign cmd_ready = !held_valid_reg || take;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (cmd_ready)
        begin
            held_valid_next = cmd_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            held_item_reg.command <= cmd_word.command;
            held_item_reg.operand <= to_bcd(cmd_word.amount);
        end
    end

    assign held_valid = held_valid_reg;
    assign held_item  = held_item_reg;

endmodule

[sv/sba_digit_alu.sv]
// decimal add, subtract and clear over the total, clamp, wrap and milestone update
module sba_digit_alu
    import sba_pkg::*;
(
    input  digits_t           total,
    input  logic [MARK_W-1:0] mark,
    input  op_item_t          item,
    output alu_out_t          result
);

    digits_t           add_total;
    digits_t           sub_total;
    logic              add_carry;
    logic              sub_borrow;
    logic [4:0]        sum5;
    logic [4:0]        need5;
    logic [MARK_W-1:0] count;

    // ripple decimal carry, least significant digit first
    always_comb
    begin
        add_carry = 1'b0;
        add_total = '0;
        sum5      = '0;
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            sum5 = {1'b0, total[i]} + {1'b0, item.operand[i]} + {4'b0, add_carry};
            if (sum5 >= 5'd10)
            begin
                add_total[i] = DIGIT_W'(sum5 - 5'd10);
                add_carry    = 1'b1;
            end
            else
            begin
                add_total[i] = DIGIT_W'(sum5);
                add_carry    = 1'b0;
            end
        end
    end

    // ripple decimal borrow
    always_comb
    begin
        sub_borrow = 1'b0;
        sub_total  = '0;
        need5      = '0;
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            need5 = {1'b0, item.operand[i]} + {4'b0, sub_borrow};
            if ({1'b0, total[i]} < need5)
            begin
                sub_total[i] = DIGIT_W'({1'b0, total[i]} + 5'd10 - need5);
                sub_borrow   = 1'b1;
            end
            else
            begin
                sub_total[i] = DIGIT_W'({1'b0, total[i]} - need5);
                sub_borrow   = 1'b0;
            end
        end
    end

    // ten-thousands count after the add
    assign count = MARK_W'(MARK_W'(add_total[TEN_K_HI]) * MARK_W'(10))
                 + MARK_W'(add_total[TEN_K_LO]);

    always_comb
    begin
        result                       = '0;
        result.total                 = total;
        result.mark                  = mark;
        unique case (item.command)
            CMD_ADD:
            begin
                result.total       = add_total;
                result.res.wrapped = add_carry;
                if (count > mark)
                begin
                    result.mark                  = count;
                    result.res.milestones_gained = count - mark;
                end
            end
            CMD_SUB:
            begin
                if (sub_borrow)
                begin
                    result.total       = '0;
                    result.res.clamped = 1'b1;
                end
                else
                begin
                    result.total = sub_total;
                end
            end
            CMD_CLEAR:
            begin
                result.total = '0;
                result.mark  = '0;
            end
            default:
            begin
                result.total = total;
            end
        endcase
        result.res.total_bcd = result.total[OUT_DIGITS-1:0];
    end

endmodule

[sv/bcd_score_accumulator_unit.sv]
// top level of the bcd score accumulator: input register, digit alu, state and result register
// a word accepted into the input register goes through the digit alu into the result register
// throughput: one command word per cycle, cmd_ready drops only while both registers are full
//   and res_ready is low
// reset: rst_n clears the bcd total, the milestone mark and both valid flags at once
// no clearing pass: the block takes words from the first cycle after reset
module bcd_score_accumulator_unit
    import sba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_word_t cmd_word,
    output logic      res_valid,
    input  logic      res_ready,
    output res_word_t res_word
);

    // input register side
    logic     held_valid;
    op_item_t held_item;
    logic     take;

    // accumulator state and result register
    digits_t           total_reg;
    digits_t           total_next;
    logic [MARK_W-1:0] mark_reg;
    logic [MARK_W-1:0] mark_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    res_word_t         res_word_reg;

    alu_out_t alu_result;

    // the held word goes through the alu when the result register is free or being emptied
    assign take = held_valid && (!res_valid_reg || res_ready);

    sba_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_word   (cmd_word),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // all decimal add and subtract work for one word happens here, between the two registers
    sba_digit_alu u_digit_alu (
        .total  (total_reg),
        .mark   (mark_reg),
        .item   (held_item),
        .result (alu_result)
    );

    // state moves only together with a result, so the next word sees the updated total
    always_comb
    begin
        total_next     = total_reg;
        mark_next      = mark_reg;
        res_valid_next = res_valid_reg;
        if (take)
        begin
            total_next     = alu_result.total;
            mark_next      = alu_result.mark;
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            mark_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            mark_reg      <= mark_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_word_reg <= alu_result.res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

`ifndef SYNTHESIS
    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mark_reg <= MARK_MAX)
        else $error("milestone mark above 99");

    a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_word_reg.clamped |-> res_word_reg.total_bcd == '0)
        else $error("clamped result with nonzero total");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_word_reg.clamped && res_word_reg.wrapped))
        else $error("clamped and wrapped on the same word");

    a_gain_tracks_mark: assert property (@(posedge clk) disable iff (!rst_n)
        take && alu_result.res.milestones_gained != '0 |=>
            mark_reg == $past(mark_reg) + $past(alu_result.res.milestones_gained))
        else $error("milestone gain does not match mark rise");

    a_take_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> res_valid_reg)
        else $error("processed word did not reach the result register");
`endif

endmodule

[bench/tb_bcd_score_accumulator_unit.sv]
// testbench for the bcd score accumulator: directed table, random words and a scoreboard
`timescale 1ns / 100ps

module tb_bcd_score_accumulator_unit
    import sba_pkg::*;
();

    // command value the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 426;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    cmd_word_t cmd_word  = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    res_word_t res_word;

    bcd_score_accumulator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // score model: six bcd digits and the ten-thousands milestone mark
    // ------------------------------------------------------------------
    logic [3:0]        score_digits [6];
    logic [MARK_W-1:0] mark_level = '0;

    // what the run reached, for the closing summary
    int wrap_count      = 0;
    int clamp_count     = 0;
    int rise_count      = 0;
    int clear_count     = 0;
    int ignored_count   = 0;
    int words_sent      = 0;
    int words_checked   = 0;
    int fail_count      = 0;
    int cycle_count     = 0;

    res_word_t expected_results[$];

    initial
    begin
        for (int i = 0; i < 6; i++)
        begin
            score_digits[i] = '0;
        end
    end

    // apply one command word to the score model and return the word the block should answer
    function automatic res_word_t apply_score_command(input cmd_word_t w);
        int         value;
        int         carry;
        int         borrow;
        int         sum;
        int         need;
        int         count;
        logic [3:0] operand [6];
        res_word_t  r;
        r = '0;
        value = int'(w.amount);
        // binary amount to decimal digits, lsd first
        for (int i = 0; i < 6; i++)
        begin
            operand[i] = 4'(value % 10);
            value = value / 10;
        end
        case (w.command)
            CMD_ADD:
            begin
                carry = 0;
                for (int i = 0; i < 6; i++)
                begin
                    sum = int'(score_digits[i]) + int'(operand[i]) + carry;
                    carry = (sum >= 10) ? 1 : 0;
                    score_digits[i] = 4'(sum - 10 * carry);
                end
                // carry out of the top digit is dropped
                r.wrapped = carry[0];
                count = int'(score_digits[5]) * 10 + int'(score_digits[4]);
                if (count > int'(mark_level))
                begin
                    r.milestones_gained = MARK_W'(count - int'(mark_level));
                    mark_level = MARK_W'(count);
                end
            end
            CMD_SUB:
            begin
                borrow = 0;
                for (int i = 0; i < 6; i++)
                begin
                    need = int'(operand[i]) + borrow;
                    if (int'(score_digits[i]) < need)
                    begin
                        score_digits[i] = 4'(int'(score_digits[i]) + 10 - need);
                        borrow = 1;
                    end
                    else
                    begin
                        score_digits[i] = 4'(int'(score_digits[i]) - need);
                        borrow = 0;
                    end
                end
                // underflow clamps the total, mark untouched
                if (borrow != 0)
                begin
                    for (int i = 0; i < 6; i++)
                    begin
                        score_digits[i] = '0;
                    end
                    r.clamped = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    score_digits[i] = '0;
                end
                mark_level = '0;
            end
            default:
            begin
                // unused command leaves the state alone
            end
        endcase
        for (int i = 0; i < 6; i++)
        begin
            r.total_bcd[4*i +: 4] = score_digits[i];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // command side: bursts of random length with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_command(input cmd_word_t w, input bit typed, input res_word_t typed_res);
        int        gap;
        res_word_t predicted;
        if (burst_left == 0)
        begin
            // drop valid for a while, then start a new burst
            cmd_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        // valid was raised at an earlier edge, so each edge here sees it high
        do
            @(posedge clk);
        while (!cmd_ready);
        burst_left--;
        predicted = apply_score_command(w);
        if (w.command == CMD_UNUSED)
            ignored_count++;
        if (w.command == CMD_CLEAR)
            clear_count++;
        if (predicted.wrapped)
            wrap_count++;
        if (predicted.clamped)
            clamp_count++;
        if (predicted.milestones_gained != '0)
            rise_count++;
        words_sent++;
        // a typed row states the answer outright, the model still tracks state
        expected_results.push_back(typed ? typed_res : predicted);
    endtask

    // ------------------------------------------------------------------
    // result side: stall pattern redrawn each time stall_phase wraps to zero and held across its cycles
    // ------------------------------------------------------------------
    int stall_mode  = 0;
    int stall_phase = 0;

    always @(posedge clk)
    begin
        if (stall_phase == 0)
            stall_mode <= $urandom_range(0, 3);
        stall_phase <= (stall_phase == 49) ? 0 : stall_phase + 1;
        case (stall_mode)
            0:       res_ready <= 1'b1;                         // no stalls
            1:       res_ready <= 1'($urandom_range(0, 1));     // coin flip
            2:       res_ready <= ($urandom_range(0, 3) == 0);  // mostly stalled
            default: res_ready <= stall_phase[0];               // alternating, follows the low phase bit
        endcase
    end

    // ------------------------------------------------------------------
    // scoreboard
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result word %0d: %s got %0h expected %0h",
                 words_checked, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        res_word_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected word, total_bcd", 32'(res_word.total_bcd), '0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_word.total_bcd !== want.total_bcd)
                    report_mismatch("total_bcd", 32'(res_word.total_bcd), 32'(want.total_bcd));
                if (res_word.milestones_gained !== want.milestones_gained)
                    report_mismatch("milestones_gained", 32'(res_word.milestones_gained),
                                    32'(want.milestones_gained));
                if (res_word.clamped !== want.clamped)
                    report_mismatch("clamped", 32'(res_word.clamped), 32'(want.clamped));
                if (res_word.wrapped !== want.wrapped)
                    report_mismatch("wrapped", 32'(res_word.wrapped), 32'(want.wrapped));
            end
            words_checked++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // directed table: one row per command, repeated reps times
    // ------------------------------------------------------------------
    typedef struct {
        logic [1:0]  command;
        logic [15:0] amount;
        int          reps;
        bit          typed;
        res_word_t   answer;
    } step_row_t;

    step_row_t step_rows[$];

    task automatic add_row(input logic [1:0] command, input logic [15:0] amount,
                           input int reps, input bit typed, input logic [23:0] total,
                           input logic [6:0] gained, input logic clamped, input logic wrapped);
        step_row_t row;
        row.command                  = command;
        row.amount                   = amount;
        row.reps                     = reps;
        row.typed                    = typed;
        row.answer.total_bcd         = total;
        row.answer.milestones_gained = gained;
        row.answer.clamped           = clamped;
        row.answer.wrapped           = wrapped;
        step_rows.push_back(row);
    endtask

    initial
    begin
        cmd_word_t w;
        int        pick;
        int        counted;

        //      command     amount      reps typed total         gain  clmp wrap
        // unused command right after reset answers the zero total
        add_row(CMD_UNUSED, 16'h0000,   1,   1,    24'h000000,   7'd0, 1'b0, 1'b0);
        // subtract from zero underflows
        add_row(CMD_SUB,    16'd1,      1,   1,    24'h000000,   7'd0, 1'b1, 1'b0);
        // exact zero after subtract is not an underflow
        add_row(CMD_SUB,    16'd0,      1,   1,    24'h000000,   7'd0, 1'b0, 1'b0);
        // largest amount, mark rises to six
        add_row(CMD_ADD,    16'hFFFF,   1,   1,    24'h065535,   7'd6, 1'b0, 1'b0);
        // climb to 983025, mark rising along the way
        add_row(CMD_ADD,    16'hFFFF,   14,  0,    24'h0,        7'd0, 1'b0, 1'b0);
        // mark reaches its top of 99
        add_row(CMD_ADD,    16'd9999,   1,   0,    24'h0,        7'd0, 1'b0, 1'b0);
        // carry past 999999 is dropped, count lands below the mark
        add_row(CMD_ADD,    16'hFFFF,   1,   0,    24'h0,        7'd0, 1'b0, 1'b0);
        // unused command with a nonzero total and a busy amount
        add_row(CMD_UNUSED, 16'hA5A5,   1,   0,    24'h0,        7'd0, 1'b0, 1'b0);
        // underflow from a nonzero total
        add_row(CMD_SUB,    16'hFFFF,   1,   1,    24'h000000,   7'd0, 1'b1, 1'b0);
        // clear drops the mark as well
        add_row(CMD_CLEAR,  16'hFFFF,   1,   1,    24'h000000,   7'd0, 1'b0, 1'b0);
        add_row(CMD_ADD,    16'hFFFF,   1,   1,    24'h065535,   7'd6, 1'b0, 1'b0);

        // reset held low, then released at an edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (step_rows[k])
        begin
            for (int n = 0; n < step_rows[k].reps; n++)
            begin
                w.command = step_rows[k].command;
                w.amount  = step_rows[k].amount;
                send_command(w, step_rows[k].typed, step_rows[k].answer);
            end
        end

        // random words, adds favored so the total climbs far enough to wrap
        counted = 0;
        while (counted < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                w.command = CMD_ADD;
            else if (pick < 90)
                w.command = CMD_SUB;
            else if (pick < 94)
                w.command = CMD_CLEAR;
            else
                w.command = CMD_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                w.amount = 16'($urandom_range(0, 65535));
            else if (pick < 70)
                w.amount = 16'($urandom_range(0, 999));
            else if (pick < 85)
                w.amount = 16'($urandom_range(0, 9999));
            else if (pick < 95)
                w.amount = 16'hFFFF;
            else
                w.amount = 16'h0000;
            send_command(w, 1'b0, '0);
            counted++;
        end
        cmd_valid <= 1'b0;

        // drain, then keep watching for any stray word
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d command words (%0d clears, %0d ignored), checked %0d result words",
                 words_sent, clear_count, ignored_count, words_checked);
        $display("reached %0d wraps, %0d underflow clamps, %0d milestone rises",
                 wrap_count, clamp_count, rise_count);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
